FILE: hdl/bsfr_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the bus sniffer frame receiver
package bsfr_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_BIT_PERIOD    = 2'd0;
    localparam logic [1:0] CFG_RESYNC_COUNT  = 2'd1;
    localparam logic [1:0] CFG_IDLE_GAP_BITS = 2'd2;

    // result kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_GAP   = 1'b1;

    // reset values of the configuration registers
    localparam logic [15:0] BIT_PERIOD_RESET    = 16'd3332;
    localparam logic [15:0] RESYNC_COUNT_RESET  = 16'd2499;
    localparam logic [7:0]  IDLE_GAP_BITS_RESET = 8'd11;

    // idle counter saturation value
    localparam logic [7:0] IDLE_COUNT_MAX = 8'hff;

    // one result beat
    typedef struct packed {
        logic        result_kind;
        logic [7:0]  data_byte;
        logic        parity_error;
        logic        start_error;
        logic        stop_error;
        logic [10:0] raw_frame;
    } result_t;

endpackage

FILE: hdl/bsfr_if.sv
`timescale 1ns / 1ps
// handshake interfaces for line samples and result beats
interface bsfr_sample_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink (input valid, input line_level, output ready);
endinterface

interface bsfr_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  data_byte;
    logic        parity_error;
    logic        start_error;
    logic        stop_error;
    logic [10:0] raw_frame;

    modport source (output valid, output result_kind, output data_byte,
                    output parity_error, output start_error, output stop_error,
                    output raw_frame, input ready);
    modport sink (input valid, input result_kind, input data_byte,
                  input parity_error, input start_error, input stop_error,
                  input raw_frame, output ready);
endinterface

FILE: hdl/bus_sniffer_frame_receiver_unit.sv
`timescale 1ns / 1ps
// top level of the bus sniffer frame receiver
// Takes one serial line sample per beat and may accept a sample in every clock.
// A bit timer paced by bit_period samples the line; a falling edge reloads the
// timer with resync_count and, while idle, starts a frame of FRAME_BITS bits
// (start, eight data, even parity, stop, least significant first). A finished
// frame, with its error flags, or an end-of-packet marker after idle_gap_bits
// idle high bit times, is registered on the sample that completes it. The
// output register and a one-entry skid stage decouple the two sides: sample
// ready falls only while both are full, so with the result side always
// ready the block sustains one sample per clock.
// Configuration writes are taken whenever the write enable is high.
module bus_sniffer_frame_receiver_unit
    import bsfr_pkg::*;
#(
    parameter int FRAME_BITS = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    bsfr_sample_if.sink         samples,
    bsfr_result_if.source       results
);

    localparam int IDX_W = $clog2(FRAME_BITS);

    // parity covers every bit between start and stop
    localparam logic [FRAME_BITS-1:0] PARITY_MASK =
        {1'b0, {(FRAME_BITS-2){1'b1}}, 1'b0};

    // configuration registers
    logic [15:0] bit_period_reg;
    logic [15:0] resync_count_reg;
    logic [7:0]  idle_gap_bits_reg;

    // receiver state
    logic [15:0]           phase_count_reg, phase_count_next;
    logic                  line_prev_reg, line_prev_next;
    logic                  receiving_reg, receiving_next;
    logic [IDX_W-1:0]      bit_index_reg, bit_index_next;
    logic [FRAME_BITS-1:0] frame_shift_reg, frame_shift_next;
    logic [7:0]            idle_count_reg, idle_count_next;

    // output register and skid stage
    result_t head_reg, head_next;
    logic    head_valid_reg, head_valid_next;
    result_t skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic                  accept;
    logic                  pop;
    logic                  line_edge;
    logic                  tick;
    logic                  emit;
    result_t               new_result;
    logic [FRAME_BITS-1:0] frame_new;
    logic [31:0]           frame_wide;
    logic [IDX_W:0]        bit_count;
    logic [7:0]            idle_inc;

    assign accept = samples.valid && samples.ready;
    assign pop    = head_valid_reg && results.ready;

    assign samples.ready = !skid_valid_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg    <= BIT_PERIOD_RESET;
            resync_count_reg  <= RESYNC_COUNT_RESET;
            idle_gap_bits_reg <= IDLE_GAP_BITS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BIT_PERIOD:    bit_period_reg    <= cfg_data;
                CFG_RESYNC_COUNT:  resync_count_reg  <= cfg_data;
                CFG_IDLE_GAP_BITS: idle_gap_bits_reg <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // edge detect and bit timer
    assign line_edge = line_prev_reg && !samples.line_level;
    assign tick      = !line_edge && (phase_count_reg >= bit_period_reg);

    // sampled frame with the current bit written in
    always_comb
    begin
        frame_new = frame_shift_reg;
        frame_new[bit_index_reg] = samples.line_level;
    end

    assign frame_wide = 32'(frame_new);
    assign bit_count  = {1'b0, bit_index_reg} + (IDX_W+1)'(1);
    assign idle_inc   = idle_count_reg + 8'd1;

    // receiver next state and result
    always_comb
    begin
        phase_count_next = phase_count_reg;
        line_prev_next   = samples.line_level;
        receiving_next   = receiving_reg;
        bit_index_next   = bit_index_reg;
        frame_shift_next = frame_shift_reg;
        idle_count_next  = idle_count_reg;
        emit             = 1'b0;
        new_result       = '0;

        if (line_edge)
        begin
            phase_count_next = resync_count_reg;
            if (!receiving_reg)
            begin
                receiving_next  = 1'b1;
                bit_index_next  = '0;
                idle_count_next = '0;
            end
        end
        else if (tick)
        begin
            phase_count_next = '0;
        end
        else
        begin
            phase_count_next = phase_count_reg + 16'd1;
        end

        if (tick)
        begin
            if (receiving_reg)
            begin
                frame_shift_next = frame_new;
                bit_index_next   = bit_count[IDX_W-1:0];
                if (bit_count == (IDX_W+1)'(FRAME_BITS))
                begin
                    emit                    = 1'b1;
                    new_result.result_kind  = KIND_FRAME;
                    new_result.data_byte    = frame_wide[8:1];
                    new_result.parity_error = ^(frame_new & PARITY_MASK);
                    new_result.start_error  = frame_new[0];
                    new_result.stop_error   = !frame_new[FRAME_BITS-1];
                    new_result.raw_frame    = frame_wide[10:0];
                    frame_shift_next        = '0;
                    bit_index_next          = '0;
                    idle_count_next         = '0;
                    receiving_next          = 1'b0;
                end
            end
            else if (samples.line_level && (idle_count_reg != IDLE_COUNT_MAX))
            begin
                idle_count_next = idle_inc;
                if (idle_inc == idle_gap_bits_reg)
                begin
                    emit                   = 1'b1;
                    new_result.result_kind = KIND_GAP;
                end
            end
        end
    end

    // receiver state registers, advanced on each accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_count_reg <= '0;
            line_prev_reg   <= 1'b1;
            receiving_reg   <= 1'b0;
            bit_index_reg   <= '0;
            frame_shift_reg <= '0;
            idle_count_reg  <= '0;
        end
        else if (accept)
        begin
            phase_count_reg <= phase_count_next;
            line_prev_reg   <= line_prev_next;
            receiving_reg   <= receiving_next;
            bit_index_reg   <= bit_index_next;
            frame_shift_reg <= frame_shift_next;
            idle_count_reg  <= idle_count_next;
        end
    end

    // output register and skid stage steering
    always_comb
    begin
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;

        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_next       = new_result;
                head_valid_next = accept && emit;
            end
        end
        else if (accept && emit)
        begin
            if (!head_valid_reg)
            begin
                head_next       = new_result;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = new_result;
                skid_valid_next = 1'b1;
            end
        end
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    // result beat
    assign results.valid        = head_valid_reg;
    assign results.result_kind  = head_reg.result_kind;
    assign results.data_byte    = head_reg.data_byte;
    assign results.parity_error = head_reg.parity_error;
    assign results.start_error  = head_reg.start_error;
    assign results.stop_error   = head_reg.stop_error;
    assign results.raw_frame    = head_reg.raw_frame;

endmodule
